@@ hw/rtl/lfu_cache_table_macros.svh @@
// assertion macros used by the lfu cache table checker
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH

// property checked outside reset
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// property that must also hold through reset
`define LFU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

@@ hw/rtl/lfu_pkg.sv @@
// package for the lfu cache table: word types, sizes and codes
`timescale 1ns / 1ps

package lfu_pkg;

    // table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 5;
    localparam int CNT_W    = 32;
    localparam int STAMP_W  = 48;
    localparam int DATA_W   = 32;

    // configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_W    = PADDR_W - 2;
    localparam logic [REG_W-1:0] REG_CAPACITY = REG_W'(0);
    localparam logic [CFG_W-1:0] CAP_RESET    = CFG_W'(16);

    // request codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // request word
    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_req;

    // response word
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } t_rsp;

endpackage

@@ hw/rtl/lfu_cache_table.sv @@
// An accepted request passes through the scan and write-back states; the result is strobed
// on o_valid after write-back. Busy blocks new requests and is low again in the result cycle.
// The scan visits one table entry a cycle through a single key/count/stamp comparator,
// then the write-back state updates the chosen entry.
// Synchronous active-low reset clears all valid bits, occupancy, the recency stamp
// and sets r_cap to 16; no clearing pass is needed. Results cannot be stalled.
`timescale 1ns / 1ps

module lfu_cache_table
    import lfu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    // result side
    output logic               o_valid,
    output t_rsp               o_rsp,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

    // table storage
    logic [CAPACITY-1:0]  r_valid;
    logic [DATA_W-1:0]    r_key   [CAPACITY];
    logic [DATA_W-1:0]    r_value [CAPACITY];
    logic [CNT_W-1:0]     r_count [CAPACITY];
    logic [STAMP_W-1:0]   r_stamp_tab [CAPACITY];

    // control and bookkeeping
    logic [1:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_idx;
    logic [OCC_W-1:0]     r_occ;
    logic [STAMP_W-1:0]   r_stamp;
    logic [CFG_W-1:0]     r_cap;
    t_req                 r_req;

    // scan findings
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [DATA_W-1:0]    r_hit_val;
    logic [CNT_W-1:0]     r_hit_cnt;
    logic                 r_vic_found;
    logic [IDX_W-1:0]     r_vic_idx;
    logic [CNT_W-1:0]     r_vic_cnt;
    logic [STAMP_W-1:0]   r_vic_stamp;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_idx;

    // output register
    logic                 r_out_valid;
    t_rsp                 r_rsp;

    logic                 accept;
    logic                 cfg_wr;
    logic                 e_valid;
    logic [DATA_W-1:0]    e_key;
    logic [CNT_W-1:0]     e_cnt;
    logic [STAMP_W-1:0]   e_stamp;
    logic                 match;
    logic                 better;
    logic                 is_free;
    logic [OCC_W-1:0]     cap_eff;
    logic                 is_put;
    logic                 upd;
    logic                 ins;
    logic                 evict;
    logic [IDX_W-1:0]     ins_slot;
    logic                 occ_inc;
    logic [CNT_W-1:0]     cnt_inc;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[PADDR_W-1:2] == REG_CAPACITY);

    // configuration read back
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_CAPACITY) begin
            prdata = PDATA_W'(r_cap);
        end
    end

    // entry under the scan pointer
    assign e_valid = r_valid[r_idx];
    assign e_key   = r_key[r_idx];
    assign e_cnt   = r_count[r_idx];
    assign e_stamp = r_stamp_tab[r_idx];

    // shared comparator: key match, victim order, first free slot
    assign match   = e_valid && !r_hit && (e_key == r_req.key);
    assign better  = e_valid && (!r_vic_found || (e_cnt < r_vic_cnt) ||
                     ((e_cnt == r_vic_cnt) && (e_stamp < r_vic_stamp)));
    assign is_free = !e_valid && !r_free_found;

    // write-back decision
    always_comb begin
        if (32'(r_cap) > 32'(CAPACITY)) begin
            cap_eff = OCC_W'(CAPACITY);
        end else begin
            cap_eff = OCC_W'(r_cap);
        end
        is_put   = (r_req.command == CMD_PUT);
        upd      = r_hit && !(is_put && (cap_eff == '0));
        evict    = (r_occ >= cap_eff) && r_vic_found;
        ins      = is_put && !r_hit && (cap_eff != '0) && (evict || r_free_found);
        ins_slot = evict ? r_vic_idx : r_free_idx;
        occ_inc  = ins && !evict;
        cnt_inc  = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + CNT_W'(1);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_LAST) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_stamp     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_WRITE);
            if (cfg_wr) begin
                r_cap <= pwdata[CFG_W-1:0];
            end
            if (r_state == S_WRITE) begin
                if (ins) begin
                    r_valid[ins_slot] <= 1'b1;
                end
                if (occ_inc) begin
                    r_occ <= r_occ + OCC_W'(1);
                end
                if (upd || ins) begin
                    r_stamp <= r_stamp + STAMP_W'(1);
                end
            end
        end
    end

    // scan pointer and findings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (accept) begin
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + IDX_W'(1);
            if (match) begin
                r_hit <= 1'b1;
            end
            if (better) begin
                r_vic_found <= 1'b1;
            end
            if (is_free) begin
                r_free_found <= 1'b1;
            end
        end
    end

    // scan payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == S_SCAN) begin
            if (match) begin
                r_hit_idx <= r_idx;
                r_hit_val <= r_value[r_idx];
                r_hit_cnt <= e_cnt;
            end
            if (better) begin
                r_vic_idx   <= r_idx;
                r_vic_cnt   <= e_cnt;
                r_vic_stamp <= e_stamp;
            end
            if (is_free) begin
                r_free_idx <= r_idx;
            end
        end
    end

    // table write-back
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            if (upd) begin
                r_count[r_hit_idx]     <= cnt_inc;
                r_stamp_tab[r_hit_idx] <= r_stamp;
                if (is_put) begin
                    r_value[r_hit_idx] <= r_req.value;
                end
            end else if (ins) begin
                r_key[ins_slot]       <= r_req.key;
                r_value[ins_slot]     <= r_req.value;
                r_count[ins_slot]     <= CNT_W'(1);
                r_stamp_tab[ins_slot] <= r_stamp;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_rsp.hit        <= r_hit;
            r_rsp.read_value <= r_hit ? r_hit_val : '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

@@ hw/rtl/lfu_chk.sv @@
// port checker for the lfu cache table, bound to the top level
`timescale 1ns / 1ps
`include "lfu_cache_table_macros.svh"

module lfu_chk
    import lfu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  logic o_valid,
    input  t_rsp o_rsp
);

    // an accepted request keeps the block busy
    `LFU_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)

    // the result word arrives as the block frees up
    `LFU_ASSERT(a_result_idle, i_clk, i_rst_n, o_valid |-> !busy)

    // a miss reports zero data
    `LFU_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_valid && !o_rsp.hit) |-> (o_rsp.read_value == '0))

    // reset leaves the block idle with no result
    `LFU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_valid))

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (.*);
